// ===== design/msq_pkg.sv =====
// ----------------------------------------------------------------------------
// Maneuver sequencer package
// Shared widths, field codes, plan entry layout and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package msq_pkg;

   localparam int EntryWidth    = 43;
   localparam int EntryCount    = 4;
   localparam int EntryIdxWidth = 2;
   localparam int CsrIdxWidth   = 8;
   localparam int SampleWidth   = 32;
   localparam int CountWidth    = 16;
   localparam int RefPosWidth   = 40;
   localparam int RefHeadWidth  = 33;
   localparam int MaxEntriesDef = 4;

   // 1000000 m and pi/2 rad in Q16.16
   localparam logic signed [RefPosWidth-1:0]  PosOffset   = 40'sd65536000000;
   localparam logic signed [RefHeadWidth-1:0] QuarterTurn = 33'sd102944;
   localparam logic [CountWidth-1:0]          CountMax    = 16'hFFFF;

   localparam logic [EntryWidth-1:0] EntryZeroRst  = 43'd858993465754;
   localparam logic [EntryWidth-1:0] EntryOneRst   = 43'd98784346112;
   localparam logic [EntryWidth-1:0] EntryTwoRst   = 43'd4398046511104;
   localparam logic [EntryWidth-1:0] EntryThreeRst = 43'd4398046511104;

   typedef enum logic [0:0] {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_RAN     = 2'd0,
      ST_NOT_RUN = 2'd1,
      ST_START   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      MT_PARK          = 3'd0,
      MT_REVERSE       = 3'd1,
      MT_REVERSE_LEFT  = 3'd2,
      MT_REVERSE_RIGHT = 3'd3,
      MT_DRIVE         = 3'd4,
      MT_DRIVE_LEFT    = 3'd5,
      MT_DRIVE_RIGHT   = 3'd6
   } maneuver_type;

   typedef enum logic [3:0] {
      TR_HEAD_ABOVE  = 4'd0,
      TR_HEAD_BELOW  = 4'd1,
      TR_DURATION    = 4'd2,
      TR_POS_ABOVE   = 4'd3,
      TR_POS_BELOW   = 4'd4,
      TR_LEFT_ABOVE  = 4'd5,
      TR_LEFT_BELOW  = 4'd6,
      TR_MID_ABOVE   = 4'd7,
      TR_MID_BELOW   = 4'd8,
      TR_RIGHT_ABOVE = 4'd9,
      TR_RIGHT_BELOW = 4'd10
   } exit_cond_type;

   typedef struct packed {
      logic                          last;
      logic [2:0]                    next;
      logic [2:0]                    kind;
      logic [3:0]                    transition;
      logic signed [SampleWidth-1:0] threshold;
   } entry_type;

endpackage

`default_nettype wire

// ===== design/msq_channels.sv =====
// ----------------------------------------------------------------------------
// Maneuver sequencer channels
// Valid/ready interfaces for step items, result items and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface msq_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   operation;
   logic [msq_pkg::SampleWidth-1:0]        time_ms;
   logic                                   controller_active;
   logic signed [msq_pkg::SampleWidth-1:0] heading;
   logic signed [msq_pkg::SampleWidth-1:0] position;
   logic signed [msq_pkg::SampleWidth-1:0] tof_left;
   logic signed [msq_pkg::SampleWidth-1:0] tof_middle;
   logic signed [msq_pkg::SampleWidth-1:0] tof_right;

   modport source (output valid, operation, time_ms, controller_active, heading,
                   position, tof_left, tof_middle, tof_right, input ready);
   modport sink (input valid, operation, time_ms, controller_active, heading,
                 position, tof_left, tof_middle, tof_right, output ready);
endinterface

interface msq_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic [1:0]                              status;
   logic [msq_pkg::CountWidth-1:0]          maneuver_count;
   logic                                    ref_valid;
   logic signed [msq_pkg::RefPosWidth-1:0]  ref_position;
   logic signed [msq_pkg::RefHeadWidth-1:0] ref_heading;

   modport source (output valid, status, maneuver_count, ref_valid, ref_position,
                   ref_heading, input ready);
   modport sink (input valid, status, maneuver_count, ref_valid, ref_position,
                 ref_heading, output ready);
endinterface

interface msq_csr_if;
   logic                             valid;
   logic                             ready;
   logic [msq_pkg::CsrIdxWidth-1:0]  index;
   logic [msq_pkg::EntryWidth-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/maneuver_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// Maneuver sequencer
// Walks a plan of up to four maneuver entries and issues controller references.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus  : start (operation 0) or step (operation 1) items with time and
//              sensor samples in Q16.16.
//   rsp_bus  : exactly one result item per request item, in order.
//   csr_bus  : writes plan entry i at index i; higher indexes are dropped.
//              Write only while no request is in flight.
// The result is registered: an item accepted at edge n shows its result
// after edge n. Throughput is one item per cycle while the receiver takes
// results; all work for an item is one entry select, one compare (duration uses
// a constant x1000 shift-add) and one offset add ahead of the result register.
// When the receiver stalls, the result register holds and req_bus.ready
// drops until the result is taken; a pending result never blocks a taken one.
// Reset clears the plan state (plan done, count one), reloads the default
// plan entries and empties the result register. Ready is low during reset.
// ----------------------------------------------------------------------------
`default_nettype none

module maneuver_sequencer_top #(
   parameter int MAX_ENTRIES = msq_pkg::MaxEntriesDef
) (
   input  wire       clock,
   input  wire       reset,
   msq_req_if.sink   req_bus,
   msq_rsp_if.source rsp_bus,
   msq_csr_if.sink   csr_bus
);

   localparam int SW = msq_pkg::SampleWidth;
   localparam int CW = msq_pkg::CountWidth;
   localparam int PW = msq_pkg::RefPosWidth;
   localparam int HW = msq_pkg::RefHeadWidth;
   localparam int DW = 49;

   // plan entries
   logic [msq_pkg::EntryWidth-1:0] entry_ff [msq_pkg::EntryCount];

   // plan state
   logic [msq_pkg::EntryIdxWidth-1:0] cur_entry_ff, cur_entry_in;
   logic                              at_end_ff, at_end_in;
   logic [CW-1:0]                     step_count_ff, step_count_in;
   logic [SW-1:0]                     begin_ms_ff, begin_ms_in;
   logic                              plan_running_ff, plan_running_in;
   logic                              man_running_ff, man_running_in;
   logic                              plan_done_ff, plan_done_in;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   msq_pkg::status_type        status_ff, status_in;
   logic [CW-1:0]              count_ff, count_in;
   logic                       ref_valid_ff, ref_valid_in;
   logic signed [PW-1:0]       ref_pos_ff, ref_pos_in;
   logic signed [HW-1:0]       ref_head_ff, ref_head_in;

   logic                       req_fire;
   msq_pkg::entry_type         entry;
   logic signed [PW-1:0]       pos_ext;
   logic signed [HW-1:0]       head_ext;
   logic [SW-1:0]              elapsed;
   logic signed [DW-1:0]       elapsed_q16;
   logic signed [DW-1:0]       thr_ext;
   logic signed [DW-1:0]       thr_ms;
   logic                       go;
   logic                       next_out;

   assign req_bus.ready = !reset && (!rsp_valid_ff || rsp_bus.ready);
   assign csr_bus.ready = !reset;
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign entry    = msq_pkg::entry_type'(entry_ff[cur_entry_ff]);
   assign pos_ext  = PW'(req_bus.position);
   assign head_ext = HW'(req_bus.heading);

   // elapsed * 65536 against threshold * 1000 (1024 - 16 - 8)
   assign elapsed     = req_bus.time_ms - begin_ms_ff;
   assign elapsed_q16 = $signed({1'b0, elapsed, 16'b0});
   assign thr_ext     = DW'(entry.threshold);
   assign thr_ms      = (thr_ext <<< 10) - (thr_ext <<< 4) - (thr_ext <<< 3);
   assign next_out    = entry.last || (32'(entry.next) >= MAX_ENTRIES);

   always_comb begin
      go = 1'b0;
      unique case (entry.transition)
         msq_pkg::TR_HEAD_ABOVE:  go = req_bus.heading > entry.threshold;
         msq_pkg::TR_HEAD_BELOW:  go = req_bus.heading < entry.threshold;
         msq_pkg::TR_DURATION:    go = elapsed_q16 > thr_ms;
         msq_pkg::TR_POS_ABOVE:   go = req_bus.position > entry.threshold;
         msq_pkg::TR_POS_BELOW:   go = req_bus.position < entry.threshold;
         msq_pkg::TR_LEFT_ABOVE:  go = req_bus.tof_left > entry.threshold;
         msq_pkg::TR_LEFT_BELOW:  go = req_bus.tof_left < entry.threshold;
         msq_pkg::TR_MID_ABOVE:   go = req_bus.tof_middle > entry.threshold;
         msq_pkg::TR_MID_BELOW:   go = req_bus.tof_middle < entry.threshold;
         msq_pkg::TR_RIGHT_ABOVE: go = req_bus.tof_right > entry.threshold;
         msq_pkg::TR_RIGHT_BELOW: go = req_bus.tof_right < entry.threshold;
         default:                 go = 1'b0;
      endcase
   end

   always_comb begin
      cur_entry_in    = cur_entry_ff;
      at_end_in       = at_end_ff;
      step_count_in   = step_count_ff;
      begin_ms_in     = begin_ms_ff;
      plan_running_in = plan_running_ff;
      man_running_in  = man_running_ff;
      plan_done_in    = plan_done_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      status_in    = status_ff;
      count_in     = count_ff;
      ref_valid_in = ref_valid_ff;
      ref_pos_in   = ref_pos_ff;
      ref_head_in  = ref_head_ff;

      if (req_fire) begin
         rsp_valid_in = 1'b1;
         status_in    = msq_pkg::ST_NOT_RUN;
         count_in     = '0;
         ref_valid_in = 1'b0;
         ref_pos_in   = '0;
         ref_head_in  = '0;
         if (req_bus.operation == msq_pkg::OP_START) begin
            // restart only once the previous plan has completed
            if (plan_done_ff) begin
               cur_entry_in    = '0;
               at_end_in       = 1'b0;
               step_count_in   = CW'(1);
               man_running_in  = 1'b0;
               plan_running_in = 1'b0;
               plan_done_in    = 1'b0;
            end
            status_in = msq_pkg::ST_START;
            count_in  = step_count_in;
         end else if (plan_done_ff || !req_bus.controller_active) begin
            status_in = msq_pkg::ST_NOT_RUN;
         end else if (at_end_ff) begin
            if (plan_running_ff) begin
               plan_running_in = 1'b0;
               plan_done_in    = 1'b1;
            end
         end else begin
            plan_running_in = 1'b1;
            status_in       = msq_pkg::ST_RAN;
            if (!man_running_ff) begin
               // new maneuver: issue its reference and latch start time
               unique case (entry.kind)
                  msq_pkg::MT_PARK: begin
                     ref_pos_in  = pos_ext;
                     ref_head_in = head_ext;
                  end
                  msq_pkg::MT_REVERSE: begin
                     ref_pos_in  = pos_ext - msq_pkg::PosOffset;
                     ref_head_in = head_ext;
                  end
                  msq_pkg::MT_REVERSE_LEFT: begin
                     ref_pos_in  = pos_ext - msq_pkg::PosOffset;
                     ref_head_in = head_ext + msq_pkg::QuarterTurn;
                  end
                  msq_pkg::MT_REVERSE_RIGHT: begin
                     ref_pos_in  = pos_ext - msq_pkg::PosOffset;
                     ref_head_in = head_ext - msq_pkg::QuarterTurn;
                  end
                  msq_pkg::MT_DRIVE: begin
                     ref_pos_in  = pos_ext + msq_pkg::PosOffset;
                     ref_head_in = head_ext;
                  end
                  msq_pkg::MT_DRIVE_LEFT: begin
                     ref_pos_in  = pos_ext + msq_pkg::PosOffset;
                     ref_head_in = head_ext - msq_pkg::QuarterTurn;
                  end
                  msq_pkg::MT_DRIVE_RIGHT: begin
                     ref_pos_in  = pos_ext + msq_pkg::PosOffset;
                     ref_head_in = head_ext + msq_pkg::QuarterTurn;
                  end
                  default: begin
                     ref_pos_in  = '0;
                     ref_head_in = '0;
                  end
               endcase
               ref_valid_in   = 1'b1;
               begin_ms_in    = req_bus.time_ms;
               man_running_in = 1'b1;
               count_in       = step_count_ff;
            end else begin
               if (go) begin
                  if (next_out) begin
                     at_end_in = 1'b1;
                  end else begin
                     cur_entry_in = entry.next[msq_pkg::EntryIdxWidth-1:0];
                  end
                  if (step_count_ff != msq_pkg::CountMax) begin
                     step_count_in = step_count_ff + CW'(1);
                  end
                  man_running_in = 1'b0;
               end
               count_in = step_count_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff[0]     <= msq_pkg::EntryZeroRst;
         entry_ff[1]     <= msq_pkg::EntryOneRst;
         entry_ff[2]     <= msq_pkg::EntryTwoRst;
         entry_ff[3]     <= msq_pkg::EntryThreeRst;
         cur_entry_ff    <= '0;
         at_end_ff       <= 1'b0;
         step_count_ff   <= CW'(1);
         begin_ms_ff     <= '0;
         plan_running_ff <= 1'b0;
         man_running_ff  <= 1'b0;
         plan_done_ff    <= 1'b1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         // drop writes beyond the last entry
         if (csr_bus.valid && csr_bus.ready &&
             csr_bus.index < msq_pkg::CsrIdxWidth'(msq_pkg::EntryCount)) begin
            entry_ff[csr_bus.index[msq_pkg::EntryIdxWidth-1:0]] <= csr_bus.data;
         end
         cur_entry_ff    <= cur_entry_in;
         at_end_ff       <= at_end_in;
         step_count_ff   <= step_count_in;
         begin_ms_ff     <= begin_ms_in;
         plan_running_ff <= plan_running_in;
         man_running_ff  <= man_running_in;
         plan_done_ff    <= plan_done_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      count_ff     <= count_in;
      ref_valid_ff <= ref_valid_in;
      ref_pos_ff   <= ref_pos_in;
      ref_head_ff  <= ref_head_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = status_ff;
   assign rsp_bus.maneuver_count = count_ff;
   assign rsp_bus.ref_valid      = ref_valid_ff;
   assign rsp_bus.ref_position   = ref_pos_ff;
   assign rsp_bus.ref_heading    = ref_head_ff;

endmodule

`default_nettype wire

// ===== design/msq_checker.sv =====
// ----------------------------------------------------------------------------
// Maneuver sequencer checker
// Port-level properties of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module msq_checker (
   input wire                                    clock,
   input wire                                    reset,
   input wire                                    req_valid,
   input wire                                    req_ready,
   input wire                                    rsp_valid,
   input wire                                    rsp_ready,
   input wire [1:0]                              rsp_status,
   input wire [msq_pkg::CountWidth-1:0]          rsp_count,
   input wire                                    rsp_ref_valid,
   input wire signed [msq_pkg::RefPosWidth-1:0]  rsp_ref_position
);

   // a stalled result holds its place
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // each taken item shows up as a result on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no result after accepted item");

   // no new item while the result register is full and stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("item taken over a stalled result");

   // references come only from a step that ran
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ref_valid |-> rsp_status == msq_pkg::ST_RAN)
      else $error("reference on a step that did not run");

   // a step that did not run reports zeros
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == msq_pkg::ST_NOT_RUN |->
         rsp_count == '0 && rsp_ref_position == '0)
      else $error("nonzero fields on a step that did not run");

endmodule

bind maneuver_sequencer_top msq_checker u_msq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_status       (rsp_bus.status),
   .rsp_count        (rsp_bus.maneuver_count),
   .rsp_ref_valid    (rsp_bus.ref_valid),
   .rsp_ref_position (rsp_bus.ref_position)
);

`default_nettype wire

// ===== tb/sv/maneuver_plan_checker.sv =====
// ----------------------------------------------------------------------------
// Maneuver plan checker
// Watches the step, result and register channels of the maneuver sequencer,
// tracks the plan state and entry registers itself, works out the guidance
// result of every accepted item and compares it field by field with the
// result items in order.
// ----------------------------------------------------------------------------
module maneuver_plan_checker #(
   parameter int MAX_ENTRIES = msq_pkg::MaxEntriesDef
) (
   input  logic clock,
   input  logic reset,
   msq_req_if   req_mon,
   msq_rsp_if   rsp_mon,
   msq_csr_if   csr_mon,
   output int   fail_count,
   output int   pending,
   output int   results_seen,
   output int   refs_issued,
   output int   plans_finished
);
   import msq_pkg::*;

   typedef struct packed {
      status_type                     status;
      logic [CountWidth-1:0]          count;
      logic                           ref_valid;
      logic signed [RefPosWidth-1:0]  ref_pos;
      logic signed [RefHeadWidth-1:0] ref_head;
   } guidance_type;

   logic [EntryWidth-1:0]    plan_regs [EntryCount];
   logic [EntryIdxWidth-1:0] cur_entry;
   logic                     at_end;
   logic                     plan_running;
   logic                     maneuver_running;
   logic                     plan_done;
   logic [CountWidth-1:0]    step_cnt;
   logic [SampleWidth-1:0]   begin_ms;
   guidance_type             guidance_q [$];
   int                       errors;
   int                       seen;
   int                       refs;
   int                       finished;

   function automatic guidance_type plan_step(
      input logic                          op,
      input logic [SampleWidth-1:0]        now,
      input logic                          active,
      input logic signed [SampleWidth-1:0] head,
      input logic signed [SampleWidth-1:0] pos,
      input logic signed [SampleWidth-1:0] rl,
      input logic signed [SampleWidth-1:0] rm,
      input logic signed [SampleWidth-1:0] rr
   );
      guidance_type                   g;
      entry_type                      e;
      logic signed [SampleWidth-1:0]  thr;
      logic signed [RefPosWidth-1:0]  p40;
      logic signed [RefHeadWidth-1:0] h33;
      logic [SampleWidth-1:0]         elapsed;
      longint                         dur_q;
      longint                         thr_q;
      logic                           go;

      g = '0;
      if (op == OP_START) begin
         if (plan_done) begin
            cur_entry        = '0;
            at_end           = 1'b0;
            step_cnt         = 1;
            maneuver_running = 1'b0;
            plan_running     = 1'b0;
            plan_done        = 1'b0;
         end
         g.status = ST_START;
         g.count  = step_cnt;
         return g;
      end

      g.status = ST_NOT_RUN;
      if (plan_done || !active) return g;
      if (at_end) begin
         if (plan_running) begin
            plan_running = 1'b0;
            plan_done    = 1'b1;
            finished++;
         end
         return g;
      end
      plan_running = 1'b1;

      e        = entry_type'(plan_regs[cur_entry]);
      thr      = e.threshold;
      g.status = ST_RAN;

      if (!maneuver_running) begin
         p40 = pos;
         h33 = head;
         case (e.kind)
            MT_PARK: ;
            MT_REVERSE: p40 = p40 - PosOffset;
            MT_REVERSE_LEFT: begin
               p40 = p40 - PosOffset;
               h33 = h33 + QuarterTurn;
            end
            MT_REVERSE_RIGHT: begin
               p40 = p40 - PosOffset;
               h33 = h33 - QuarterTurn;
            end
            MT_DRIVE: p40 = p40 + PosOffset;
            MT_DRIVE_LEFT: begin
               p40 = p40 + PosOffset;
               h33 = h33 - QuarterTurn;
            end
            MT_DRIVE_RIGHT: begin
               p40 = p40 + PosOffset;
               h33 = h33 + QuarterTurn;
            end
            default: begin
               p40 = '0;
               h33 = '0;
            end
         endcase
         begin_ms         = now;
         maneuver_running = 1'b1;
         refs++;
         g.count     = step_cnt;
         g.ref_valid = 1'b1;
         g.ref_pos   = p40;
         g.ref_head  = h33;
         return g;
      end

      // elapsed ms in Q16.16 against threshold seconds times 1000
      elapsed = now - begin_ms;
      dur_q   = longint'({16'd0, elapsed, 16'd0});
      thr_q   = longint'(thr) * 1000;
      case (e.transition)
         TR_HEAD_ABOVE:  go = head > thr;
         TR_HEAD_BELOW:  go = head < thr;
         TR_DURATION:    go = dur_q > thr_q;
         TR_POS_ABOVE:   go = pos > thr;
         TR_POS_BELOW:   go = pos < thr;
         TR_LEFT_ABOVE:  go = rl > thr;
         TR_LEFT_BELOW:  go = rl < thr;
         TR_MID_ABOVE:   go = rm > thr;
         TR_MID_BELOW:   go = rm < thr;
         TR_RIGHT_ABOVE: go = rr > thr;
         TR_RIGHT_BELOW: go = rr < thr;
         default:        go = 1'b0;
      endcase
      if (go) begin
         if (e.last || e.next >= MAX_ENTRIES) at_end = 1'b1;
         else cur_entry = e.next[EntryIdxWidth-1:0];
         if (step_cnt != CountMax) step_cnt++;
         maneuver_running = 1'b0;
      end
      g.count = step_cnt;
      return g;
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      errors++;
      if (errors <= 40) begin
         $display("mismatch in %s of result %0d: got %h, expected %h",
                  field, seen, got, want);
      end
   endtask

   always @(posedge clock) begin
      guidance_type want;
      if (reset) begin
         plan_regs[0]     = EntryZeroRst;
         plan_regs[1]     = EntryOneRst;
         plan_regs[2]     = EntryTwoRst;
         plan_regs[3]     = EntryThreeRst;
         cur_entry        = '0;
         at_end           = 1'b0;
         step_cnt         = 1;
         begin_ms         = '0;
         plan_running     = 1'b0;
         maneuver_running = 1'b0;
         plan_done        = 1'b1;
         guidance_q.delete();
      end else begin
         // drop writes beyond the last entry
         if (csr_mon.valid && csr_mon.ready && csr_mon.index < EntryCount) begin
            plan_regs[csr_mon.index[EntryIdxWidth-1:0]] = csr_mon.data;
         end
         if (req_mon.valid && req_mon.ready) begin
            guidance_q.push_back(plan_step(req_mon.operation, req_mon.time_ms,
                                           req_mon.controller_active, req_mon.heading,
                                           req_mon.position, req_mon.tof_left,
                                           req_mon.tof_middle, req_mon.tof_right));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen++;
            if (guidance_q.size() == 0) begin
               report_mismatch("result with nothing expected", '0, '0);
            end else begin
               want = guidance_q.pop_front();
               if (rsp_mon.status !== want.status)
                  report_mismatch("status", rsp_mon.status, want.status);
               if (rsp_mon.maneuver_count !== want.count)
                  report_mismatch("maneuver_count", rsp_mon.maneuver_count, want.count);
               if (rsp_mon.ref_valid !== want.ref_valid)
                  report_mismatch("ref_valid", rsp_mon.ref_valid, want.ref_valid);
               if (rsp_mon.ref_position !== want.ref_pos)
                  report_mismatch("ref_position", rsp_mon.ref_position, want.ref_pos);
               if (rsp_mon.ref_heading !== want.ref_head)
                  report_mismatch("ref_heading", rsp_mon.ref_heading, want.ref_head);
            end
         end
      end
      pending        <= guidance_q.size();
      fail_count     <= errors;
      results_seen   <= seen;
      refs_issued    <= refs;
      plans_finished <= finished;
   end

endmodule

// ===== tb/sv/maneuver_sequencer_top_tb.sv =====
// ----------------------------------------------------------------------------
// Maneuver sequencer testbench
// Resets the sequencer, runs a short directed walk through start, pause,
// plan end and completion, then many random plans with random samples, an
// all-zero and an all-one plan, and a looping plan stepped back to back.
// Sender bursts and receiver stalls vary, except during the looping plan.
// ----------------------------------------------------------------------------
module maneuver_sequencer_top_tb;
   import msq_pkg::*;

   localparam int CycleLimit  = 1_000_000;
   localparam int PhaseCount  = 12;
   localparam int PhaseItems  = 100;
   localparam int LoopSteps   = 60;
   localparam logic signed [SampleWidth-1:0] SampleMin = 32'sh8000_0000;
   localparam logic signed [SampleWidth-1:0] SampleMax = 32'sh7FFF_FFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;

   msq_req_if req_bus ();
   msq_rsp_if rsp_bus ();
   msq_csr_if csr_bus ();

   int                     fail_count;
   int                     pending;
   int                     results_seen;
   int                     refs_issued;
   int                     plans_finished;
   int                     cycles;
   int                     burst_left;
   logic                   no_idle = 1'b0;
   logic [1:0]             stall_mode = 2'd0;
   logic [5:0]             stall_tick = 6'd0;
   logic [SampleWidth-1:0] clock_ms;
   logic [EntryWidth-1:0]  plan_words [EntryCount];

   maneuver_sequencer_top u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   maneuver_plan_checker u_plan_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_mon        (csr_bus),
      .fail_count     (fail_count),
      .pending        (pending),
      .results_seen   (results_seen),
      .refs_issued    (refs_issued),
      .plans_finished (plans_finished)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("run timed out after %0d cycles", cycles);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver: a new stall pattern whenever stall_tick wraps, mode zero never stalls
   always @(posedge clock) begin
      stall_tick <= stall_tick + 6'd1;
      if (stall_tick == 6'd0) stall_mode <= 2'($urandom_range(0, 3));
      if (no_idle) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         case (stall_mode)
            2'd0:    rsp_bus.ready <= 1'b1;
            2'd1:    rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            2'd2:    rsp_bus.ready <= ($urandom_range(0, 2) == 0);
            default: rsp_bus.ready <= (stall_tick[2:0] < 3'd5);
         endcase
      end
   end

   function automatic logic signed [SampleWidth-1:0] random_sample();
      case ($urandom_range(0, 7))
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 3))
               0:       return SampleMin;
               1:       return SampleMax;
               2:       return '0;
               default: return -1;
            endcase
         end
         default: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      endcase
   endfunction

   function automatic logic [EntryWidth-1:0] pack_entry(
      input logic                          last,
      input logic [2:0]                    next,
      input logic [2:0]                    kind,
      input logic [3:0]                    tr,
      input logic signed [SampleWidth-1:0] thr
   );
      return {last, next, kind, tr, thr};
   endfunction

   function automatic logic [EntryWidth-1:0] random_entry(input int slot);
      logic [3:0]                    tr;
      logic signed [SampleWidth-1:0] thr;
      logic [2:0]                    nxt;
      tr  = ($urandom_range(0, 31) == 0) ? 4'($urandom_range(11, 15))
                                         : 4'($urandom_range(0, 10));
      thr = (tr == TR_DURATION) ? 32'($urandom_range(0, 3 << 16)) : random_sample();
      nxt = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'(slot + 1);
      return pack_entry($urandom_range(0, 5) == 0, nxt, 3'($urandom_range(0, 7)), tr, thr);
   endfunction

   task automatic write_csr(input logic [CsrIdxWidth-1:0] idx,
                            input logic [EntryWidth-1:0] word);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= word;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
   endtask

   // write all four entries and one out-of-range index, then release the port
   task automatic load_plan();
      for (int i = 0; i < EntryCount; i++) write_csr(CsrIdxWidth'(i), plan_words[i]);
      write_csr(CsrIdxWidth'($urandom_range(EntryCount, 255)),
                EntryWidth'({$urandom, $urandom}));
      csr_bus.valid <= 1'b0;
   endtask

   task automatic send_item(
      input op_type                        op,
      input logic [SampleWidth-1:0]        now,
      input logic                          active,
      input logic signed [SampleWidth-1:0] head,
      input logic signed [SampleWidth-1:0] pos,
      input logic signed [SampleWidth-1:0] rl,
      input logic signed [SampleWidth-1:0] rm,
      input logic signed [SampleWidth-1:0] rr
   );
      int gap;
      if (burst_left == 0 && !no_idle) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) burst_left--;
      req_bus.valid             <= 1'b1;
      req_bus.operation         <= op;
      req_bus.time_ms           <= now;
      req_bus.controller_active <= active;
      req_bus.heading           <= head;
      req_bus.position          <= pos;
      req_bus.tof_left          <= rl;
      req_bus.tof_middle        <= rm;
      req_bus.tof_right         <= rr;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic random_item();
      op_type op;
      op = ($urandom_range(0, 9) == 0) ? OP_START : OP_STEP;
      case ($urandom_range(0, 19))
         0:       clock_ms = $urandom;
         1:       clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
         default: clock_ms = clock_ms + $urandom_range(0, 600);
      endcase
      send_item(op, clock_ms, $urandom_range(0, 11) != 0, random_sample(), random_sample(),
                random_sample(), random_sample(), random_sample());
   endtask

   // hold the sender until every expected result has come back
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin
      req_bus.valid             <= 1'b0;
      req_bus.operation         <= OP_STEP;
      req_bus.time_ms           <= '0;
      req_bus.controller_active <= 1'b0;
      req_bus.heading           <= '0;
      req_bus.position          <= '0;
      req_bus.tof_left          <= '0;
      req_bus.tof_middle        <= '0;
      req_bus.tof_right         <= '0;
      csr_bus.valid             <= 1'b0;
      csr_bus.index             <= '0;
      csr_bus.data              <= '0;
      burst_left = 0;
      clock_ms   = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // default plan: completed plan, start, pause, extremes, start while running
      send_item(OP_STEP, 0, 1'b1, 0, 0, 0, 0, 0);
      send_item(OP_START, 0, 1'b0, 0, 0, 0, 0, 0);
      send_item(OP_STEP, 10, 1'b0, 0, 0, 0, 0, 0);
      send_item(OP_STEP, 20, 1'b1, SampleMin, SampleMin, SampleMin, SampleMin, SampleMin);
      send_item(OP_START, 25, 1'b1, 0, 0, 0, 0, 0);
      send_item(OP_STEP, 30, 1'b1, SampleMax, SampleMax, SampleMax, SampleMin, SampleMax);
      send_item(OP_STEP, 40, 1'b1, SampleMax, SampleMax, SampleMax, SampleMax, SampleMax);
      send_item(OP_STEP, 32'hFFFF_FFFF, 1'b1, 0, 0, SampleMax, SampleMax, SampleMin);
      wait_idle();

      // duration, unknown type, next index past the table, then completion
      plan_words[0] = pack_entry(1'b0, 3'd1, MT_DRIVE_RIGHT, TR_DURATION, 32'sh0001_0000);
      plan_words[1] = pack_entry(1'b0, 3'd2, 3'd7, TR_DURATION, 32'sh0001_0000);
      plan_words[2] = pack_entry(1'b0, 3'd6, MT_REVERSE_RIGHT, TR_HEAD_ABOVE, 0);
      plan_words[3] = pack_entry(1'b1, 3'd0, MT_PARK, TR_POS_BELOW, 0);
      load_plan();
      send_item(OP_STEP, 1000, 1'b1, 0, 0, 0, 0, 0);
      send_item(OP_STEP, 1500, 1'b1, 0, 0, 0, 0, 0);
      send_item(OP_STEP, 2001, 1'b1, 0, 0, 0, 0, 0);
      send_item(OP_STEP, 2002, 1'b1, 0, 0, 0, 0, 0);
      send_item(OP_STEP, 3003, 1'b1, 0, 0, 0, 0, 0);
      send_item(OP_STEP, 3004, 1'b1, 5, 0, 0, 0, 0);
      send_item(OP_STEP, 3005, 1'b1, 0, 0, 0, 0, 0);
      send_item(OP_STEP, 3006, 1'b1, 1, 0, 0, 0, 0);
      send_item(OP_STEP, 3007, 1'b0, 1, 0, 0, 0, 0);
      send_item(OP_STEP, 3008, 1'b1, 1, 0, 0, 0, 0);
      send_item(OP_STEP, 3009, 1'b1, 1, 0, 0, 0, 0);
      send_item(OP_START, 3010, 1'b1, 0, 0, 0, 0, 0);
      clock_ms = 3010;

      for (int phase = 0; phase < PhaseCount; phase++) begin
         wait_idle();
         for (int i = 0; i < EntryCount; i++) begin
            if (phase == 3) plan_words[i] = '0;
            else if (phase == 7) plan_words[i] = '1;
            else plan_words[i] = random_entry(i);
         end
         load_plan();
         for (int n = 0; n < PhaseItems; n++) begin
            if (n == PhaseItems / 2 && phase % 4 == 1) wait_idle();
            random_item();
         end

         if (phase == 5) begin
            // looping plan that always advances: cycle through every entry back to back
            wait_idle();
            for (int i = 0; i < EntryCount; i++) begin
               plan_words[i] = pack_entry(1'b0, 3'((i + 1) % EntryCount), 3'(i * 2),
                                          TR_DURATION, SampleMin);
            end
            load_plan();
            no_idle <= 1'b1;
            send_item(OP_START, clock_ms, 1'b1, 0, 0, 0, 0, 0);
            send_item(OP_STEP, clock_ms, 1'b1, 0, 0, 0, 0, 0);
            send_item(OP_START, clock_ms, 1'b1, 0, 0, 0, 0, 0);
            repeat (LoopSteps) begin
               clock_ms = clock_ms + 1;
               send_item(OP_STEP, clock_ms, 1'b1, random_sample(), random_sample(),
                         random_sample(), random_sample(), random_sample());
            end
            wait_idle();
            no_idle <= 1'b0;
         end
      end

      wait_idle();
      repeat (4) @(posedge clock);
      $display("checked %0d results carrying %0d references; %0d plans ran to completion",
               results_seen, refs_issued, plans_finished);
      $display("plans: default, directed, %0d random, all-zero, all-one, looping",
               PhaseCount - 2);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
